[rtl/lbc_pkg.sv]
package lbc_pkg;

    // request modes
    localparam logic [1:0] MODE_GET     = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_WRITTEN  = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_NO_BUF   = 3'd4;
    localparam logic [2:0] ST_NOT_HELD = 3'd5;

    // field widths
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;      // latch the accepted request
        logic scan_start;    // rewind the slot counter and clear the trackers
        logic scan_en;       // issue reads over all slots
        logic init_en;       // rank clearing pass after reset
        logic rd_slot;       // read the rank of the requested slot
        logic cap_rel;       // capture the rank of the released slot
        logic sweep_wr;      // scan pass is a rank sweep rather than a lookup
        logic commit_get;    // apply the lookup result
        logic commit_rel;    // apply the release
        logic commit_simple; // write request or rejected request
    } lbc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] mode;
        logic       slot_held;
        logic       scan_done;
        logic       init_done;
        logic       out_free;
    } lbc_stat_t;

endpackage

[rtl/lbc_ctrl.sv]
module lbc_ctrl
    import lbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lbc_stat_t stat,
    output lbc_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_INIT          = 10'b00_0000_0001,
        S_IDLE          = 10'b00_0000_0010,
        S_DECODE        = 10'b00_0000_0100,
        S_SCAN          = 10'b00_0000_1000,
        S_GET_COMMIT    = 10'b00_0001_0000,
        S_REL_RD        = 10'b00_0010_0000,
        S_REL_CAP       = 10'b00_0100_0000,
        S_SWEEP         = 10'b00_1000_0000,
        S_REL_COMMIT    = 10'b01_0000_0000,
        S_SIMPLE_COMMIT = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.init_en = 1'b1;
                if (stat.init_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.mode == MODE_GET) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end else if (stat.mode == MODE_RELEASE && stat.slot_held) begin
                    state_next = S_REL_RD;
                end else begin
                    state_next = S_SIMPLE_COMMIT;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_GET_COMMIT;
                end
            end
            S_GET_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit_get = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REL_RD: begin
                cmd.rd_slot = 1'b1;
                state_next  = S_REL_CAP;
            end
            S_REL_CAP: begin
                cmd.cap_rel    = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SWEEP;
            end
            S_SWEEP: begin
                cmd.scan_en  = 1'b1;
                cmd.sweep_wr = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_REL_COMMIT;
                end
            end
            S_REL_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit_rel = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SIMPLE_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit_simple = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

[rtl/lbc_dp.sv]
module lbc_dp
    import lbc_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lbc_cmd_t            cmd,
    output lbc_stat_t           stat,
    input  logic [1:0]          in_mode,
    input  logic [DEV_W-1:0]    in_device,
    input  logic [BLK_W-1:0]    in_block,
    input  logic [SLOT_W-1:0]   in_slot,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [SLOT_W-1:0]   out_slot
);

    localparam int SW    = $clog2(SLOTS);
    localparam int AW    = SW + 1;
    localparam int TAG_W = DEV_W + BLK_W;

    // latched request
    logic [1:0]        mode_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [SLOT_W-1:0] slot_reg;

    // per-slot flags
    logic [SLOTS-1:0] present_reg;
    logic [SLOTS-1:0] held_reg;
    logic [SLOTS-1:0] dirty_reg;
    logic [SLOTS-1:0] cvalid_reg;

    // tag and rank memories
    logic [TAG_W-1:0] tag_mem  [SLOTS];
    logic [SW-1:0]    rank_mem [SLOTS];
    logic [TAG_W-1:0] tag_rd_reg;
    logic [SW-1:0]    rank_rd_reg;

    // scan pipeline
    logic [AW-1:0] addr_reg;
    logic [SW-1:0] rd_idx_reg;
    logic          rd_vld_reg;

    // best candidates
    logic          hit_found_reg;
    logic [SW-1:0] hit_slot_reg;
    logic [SW-1:0] hit_rank_reg;
    logic          vic_found_reg;
    logic [SW-1:0] vic_slot_reg;
    logic [SW-1:0] vic_rank_reg;
    logic [SW-1:0] rel_rank_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    logic          slot_in_range;
    logic [SW-1:0] slot_idx;
    logic          slot_held;
    logic          issue;
    logic [SW-1:0] rd_addr;
    logic          cand_free;
    logic          hit_take;
    logic          vic_take;
    logic          sweep_dec;
    logic          out_free;
    logic          grant;
    logic [SW-1:0] chosen;

    assign slot_in_range = (32'(slot_reg) < SLOTS);
    assign slot_idx      = SW'(slot_reg);
    assign slot_held     = slot_in_range && held_reg[slot_idx];
    assign issue         = cmd.scan_en && (addr_reg < AW'(SLOTS));
    assign rd_addr       = cmd.rd_slot ? slot_idx : addr_reg[SW-1:0];
    assign out_free      = !out_valid_reg || out_ready;

    // candidate tests on registered read data
    assign cand_free = rd_vld_reg && !cmd.sweep_wr && !held_reg[rd_idx_reg];
    assign hit_take  = cand_free && present_reg[rd_idx_reg]
                       && (tag_rd_reg == {dev_reg, blk_reg})
                       && (!hit_found_reg || rank_rd_reg > hit_rank_reg);
    assign vic_take  = cand_free && !dirty_reg[rd_idx_reg]
                       && (!vic_found_reg || rank_rd_reg < vic_rank_reg);
    assign sweep_dec = rd_vld_reg && cmd.sweep_wr && (rank_rd_reg > rel_rank_reg);

    assign grant  = hit_found_reg || vic_found_reg;
    assign chosen = hit_found_reg ? hit_slot_reg : vic_slot_reg;

    // request latch
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            mode_reg <= in_mode;
            dev_reg  <= in_device;
            blk_reg  <= in_block;
            slot_reg <= in_slot;
        end
    end

    // slot counter and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.scan_start) begin
                addr_reg <= '0;
            end else if (issue || (cmd.init_en && addr_reg < AW'(SLOTS))) begin
                addr_reg <= addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= addr_reg[SW-1:0];
    end

    // tag memory
    always_ff @(posedge aclk) begin
        if (cmd.commit_get && !hit_found_reg && vic_found_reg) begin
            tag_mem[vic_slot_reg] <= {dev_reg, blk_reg};
        end
        tag_rd_reg <= tag_mem[addr_reg[SW-1:0]];
    end

    // rank memory: clearing pass, sweep decrement, release to most recent
    always_ff @(posedge aclk) begin
        if (cmd.init_en && addr_reg < AW'(SLOTS)) begin
            rank_mem[addr_reg[SW-1:0]] <= addr_reg[SW-1:0];
        end else if (sweep_dec) begin
            rank_mem[rd_idx_reg] <= rank_rd_reg - SW'(1);
        end else if (cmd.commit_rel) begin
            rank_mem[slot_idx] <= SW'(SLOTS - 1);
        end
        rank_rd_reg <= rank_mem[rd_addr];
    end

    // candidate trackers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end else begin
            if (hit_take) begin
                hit_found_reg <= 1'b1;
            end
            if (vic_take) begin
                vic_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hit_take) begin
            hit_slot_reg <= rd_idx_reg;
            hit_rank_reg <= rank_rd_reg;
        end
        if (vic_take) begin
            vic_slot_reg <= rd_idx_reg;
            vic_rank_reg <= rank_rd_reg;
        end
        if (cmd.cap_rel) begin
            rel_rank_reg <= rank_rd_reg;
        end
    end

    // slot flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            held_reg    <= '0;
            dirty_reg   <= '0;
            cvalid_reg  <= '0;
        end else begin
            if (cmd.commit_get && grant) begin
                held_reg[chosen]   <= 1'b1;
                cvalid_reg[chosen] <= 1'b1;
                present_reg[chosen] <= 1'b1;
            end
            if (cmd.commit_simple && mode_reg == MODE_WRITE && slot_held) begin
                dirty_reg[slot_idx] <= 1'b1;
            end
            if (cmd.commit_rel) begin
                held_reg[slot_idx] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit_get || cmd.commit_rel || cmd.commit_simple) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_get) begin
            if (!grant) begin
                out_status_reg <= ST_NO_BUF;
                out_slot_reg   <= '0;
            end else begin
                out_status_reg <= (hit_found_reg && cvalid_reg[hit_slot_reg]) ? ST_HIT
                                                                               : ST_MISS;
                out_slot_reg   <= SLOT_W'(chosen);
            end
        end else if (cmd.commit_rel) begin
            out_status_reg <= ST_RELEASED;
            out_slot_reg   <= slot_reg;
        end else if (cmd.commit_simple) begin
            out_status_reg <= (mode_reg == MODE_WRITE && slot_held) ? ST_WRITTEN
                                                                     : ST_NOT_HELD;
            out_slot_reg   <= slot_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

    // status to the controller
    assign stat.mode      = mode_reg;
    assign stat.slot_held = slot_held;
    assign stat.scan_done = (addr_reg == AW'(SLOTS)) && !rd_vld_reg && !issue;
    assign stat.init_done = (addr_reg == AW'(SLOTS));
    assign stat.out_free  = out_free;

`ifndef SYNTHESIS
    // a hit never grants a held slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_get && hit_found_reg |-> !held_reg[hit_slot_reg])
        else $error("hit granted a held slot");

    // a recycled slot is neither held nor dirty
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_get && !hit_found_reg && vic_found_reg
        |-> !held_reg[vic_slot_reg] && !dirty_reg[vic_slot_reg])
        else $error("recycled a held or dirty slot");

    // a result is only written when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit_get || cmd.commit_rel || cmd.commit_simple) |-> out_free)
        else $error("result overwritten before transfer");

    // dirty marks are never cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((dirty_reg & $past(dirty_reg)) == $past(dirty_reg)))
        else $error("dirty mark cleared");
`endif

endmodule

[rtl/lru_block_buffer_cache_top.sv]
// Tag and recency manager for a buffer cache of SLOTS block slots.
// Requests arrive on the s_ channel, one transfer per request; every
// request produces exactly one result transfer on the m_ channel.
// A get scans all slots once through the tag and rank memories, tracking
// the most recent free matching slot and the least recent free clean slot,
// then grants one of them. A release reads the slot's rank and sweeps the
// rank memory once to move it to the most recent end. Write and rejected
// requests go from decode straight to their commit step. One request is in
// work at a time; s_tready is high only when the controller is idle.
// After reset the rank memory is loaded by a clearing pass (slot i gets
// rank i), and s_tready stays low until that pass ends; all slot flags
// clear at once. The result sits in an output register: a new request is
// taken while it waits, and a finished request holds in its commit step
// until m_tready drains the register.
module lru_block_buffer_cache_top
    import lbc_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // mode[1:0], device[9:2], block_number[41:10], slot[45:42]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // status[2:0], slot_out[6:3]
);

    lbc_cmd_t            cmd;
    lbc_stat_t           stat;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;

    lbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lbc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (s_tdata[1:0]),
        .in_device  (s_tdata[9:2]),
        .in_block   (s_tdata[41:10]),
        .in_slot    (s_tdata[45:42]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status),
        .out_slot   (slot_out)
    );

    // pack the result
    assign m_tdata = {1'b0, slot_out, status};

endmodule

[tb/lru_block_buffer_cache_top_tb.sv]
`timescale 1ns / 100ps

module lru_block_buffer_cache_top_tb;
    import lbc_pkg::*;

    localparam int SLOTS       = 16;
    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1825;
    localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DIRTY_CAP   = 12;

    // one directed request, with an optional hand-written answer
    typedef struct packed {
        logic [1:0]          mode;
        logic [DEV_W-1:0]    dev;
        logic [BLK_W-1:0]    blk;
        logic [SLOT_W-1:0]   slot;
        logic                typed;
        logic [STATUS_W-1:0] st;
        logic [SLOT_W-1:0]   so;
    } req_row_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } cache_answer_t;

    // directed requests: reuse, dirty path, rejects, filling every slot, no buffer
    localparam req_row_t DIRECTED_REQS [N_DIRECTED] = '{
        '{MODE_GET,     8'h00, 32'h0000_0000, 4'h0, 1'b1, ST_MISS,     4'd0},
        '{MODE_GET,     8'h00, 32'h0000_0000, 4'h0, 1'b1, ST_MISS,     4'd1},
        '{MODE_WRITE,   8'h00, 32'h0000_0000, 4'h0, 1'b1, ST_WRITTEN,  4'd0},
        '{MODE_RELEASE, 8'h00, 32'h0000_0000, 4'h0, 1'b1, ST_RELEASED, 4'd0},
        '{MODE_GET,     8'h00, 32'h0000_0000, 4'h0, 1'b0, ST_HIT,      4'd0},
        '{MODE_WRITE,   8'h00, 32'h0000_0000, 4'hf, 1'b1, ST_NOT_HELD, 4'd15},
        '{MODE_RELEASE, 8'h00, 32'h0000_0000, 4'h9, 1'b1, ST_NOT_HELD, 4'd9},
        '{2'd3,         8'hff, 32'hffff_ffff, 4'hf, 1'b1, ST_NOT_HELD, 4'd15},
        '{MODE_GET,     8'hff, 32'hffff_ffff, 4'hf, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h01, 32'h0000_0001, 4'h1, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h02, 32'h0000_0002, 4'h2, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h04, 32'h0000_0100, 4'h4, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h08, 32'h0001_0000, 4'h8, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h10, 32'h0100_0000, 4'h0, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h20, 32'h8000_0000, 4'h0, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h40, 32'h5555_5555, 4'h5, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h80, 32'haaaa_aaaa, 4'ha, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h00, 32'h0000_0001, 4'h0, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'hff, 32'h0000_0000, 4'h0, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h7f, 32'h7fff_ffff, 4'h7, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h01, 32'h0000_0002, 4'h0, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h01, 32'h0000_0003, 4'h0, 1'b0, ST_HIT,      4'd0},
        '{MODE_GET,     8'h00, 32'h0000_0000, 4'h0, 1'b1, ST_NO_BUF,   4'd0},
        '{MODE_RELEASE, 8'h00, 32'h0000_0000, 4'h1, 1'b1, ST_RELEASED, 4'd1},
        '{MODE_GET,     8'h00, 32'h0000_0000, 4'h0, 1'b0, ST_HIT,      4'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // mode[1:0], device[9:2], block_number[41:10], slot[45:42]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // status[2:0], slot_out[6:3]

    // shadow of the cache bookkeeping
    logic [DEV_W-1:0]  tag_dev  [SLOTS];
    logic [BLK_W-1:0]  tag_blk  [SLOTS];
    logic [SLOTS-1:0]  tag_valid;
    logic [SLOTS-1:0]  held;
    logic [SLOTS-1:0]  dirty;
    logic [SLOTS-1:0]  filled;
    logic [SLOT_W-1:0] rank_of  [SLOTS];

    cache_answer_t answers_due [$];
    cache_answer_t want;
    int            n_sent;
    int            n_errors;
    int            cycle_cnt;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            stall_left;
    bit            long_stall_done;

    lru_block_buffer_cache_top #(
        .SLOTS(SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // slot currently holding a given recency rank
    function automatic int slot_at_rank(input int r);
        int i;
        int s;
        s = 0;
        for (i = 0; i < SLOTS; i++) begin
            if (rank_of[i] == r[SLOT_W-1:0]) s = i;
        end
        return s;
    endfunction

    // apply one request to the shadow state and work out the answer
    task automatic predict_cache_answer(
        input  logic [1:0]          mode,
        input  logic [DEV_W-1:0]    dev,
        input  logic [BLK_W-1:0]    blk,
        input  logic [SLOT_W-1:0]   slot,
        output logic [STATUS_W-1:0] st,
        output logic [SLOT_W-1:0]   so
    );
        int r;
        int s;
        int pick;
        logic [SLOT_W-1:0] old_rank;
        st = ST_NOT_HELD;
        so = slot;
        case (mode)
            MODE_GET: begin
                pick = -1;
                // lookup among free slots, most recent first
                for (r = SLOTS - 1; r >= 0 && pick < 0; r--) begin
                    s = slot_at_rank(r);
                    if (!held[s] && tag_valid[s] && tag_dev[s] == dev && tag_blk[s] == blk)
                        pick = s;
                end
                // recycle the least recent free clean slot
                for (r = 0; r < SLOTS && pick < 0; r++) begin
                    s = slot_at_rank(r);
                    if (!held[s] && !dirty[s]) begin
                        pick         = s;
                        tag_dev[s]   = dev;
                        tag_blk[s]   = blk;
                        tag_valid[s] = 1'b1;
                        filled[s]    = 1'b0;
                    end
                end
                if (pick < 0) begin
                    st = ST_NO_BUF;
                    so = '0;
                end else begin
                    held[pick]   = 1'b1;
                    st           = filled[pick] ? ST_HIT : ST_MISS;
                    filled[pick] = 1'b1;
                    so           = pick[SLOT_W-1:0];
                end
            end
            MODE_WRITE: begin
                if (held[slot]) begin
                    dirty[slot] = 1'b1;
                    st          = ST_WRITTEN;
                end
            end
            MODE_RELEASE: begin
                if (held[slot]) begin
                    held[slot] = 1'b0;
                    old_rank   = rank_of[slot];
                    for (s = 0; s < SLOTS; s++) begin
                        if (rank_of[s] > old_rank) rank_of[s] = rank_of[s] - 1'b1;
                    end
                    rank_of[slot] = SLOT_W'(SLOTS - 1);
                    st            = ST_RELEASED;
                end
            end
            default: ;
        endcase
    endtask

    // offer one request, wait for the transfer, record what should come back
    task automatic send_request(
        input logic [1:0]          mode,
        input logic [DEV_W-1:0]    dev,
        input logic [BLK_W-1:0]    blk,
        input logic [SLOT_W-1:0]   slot,
        input logic                typed,
        input logic [STATUS_W-1:0] typed_st,
        input logic [SLOT_W-1:0]   typed_so
    );
        logic [STATUS_W-1:0] st;
        logic [SLOT_W-1:0]   so;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, slot, blk, dev, mode};
        do @(posedge aclk); while (!s_tready);
        predict_cache_answer(mode, dev, blk, slot, st, so);
        if (typed) answers_due.push_back('{typed_st, typed_so});
        else answers_due.push_back('{st, so});
        n_sent++;
        @(negedge aclk);
    endtask

    // mostly well-formed traffic: gets from a small tag pool, writes and
    // releases of held slots, plus some rejected requests
    task automatic pick_request(
        output logic [1:0]        mode,
        output logic [DEV_W-1:0]  dev,
        output logic [BLK_W-1:0]  blk,
        output logic [SLOT_W-1:0] slot
    );
        int held_slots [$];
        int dirty_cnt;
        int get_pct;
        int r;
        int i;
        dirty_cnt = 0;
        for (i = 0; i < SLOTS; i++) begin
            if (held[i]) held_slots.push_back(i);
            if (dirty[i]) dirty_cnt++;
        end
        case ($urandom_range(3))
            0:       dev = 8'h00;
            1:       dev = 8'h01;
            2:       dev = 8'hff;
            default: dev = DEV_W'($urandom);
        endcase
        case ($urandom_range(7))
            0:       blk = 32'hffff_ffff;
            1:       blk = $urandom;
            default: blk = BLK_W'($urandom_range(5));
        endcase
        slot    = SLOT_W'($urandom);
        mode    = MODE_GET;
        get_pct = (held_slots.size() >= 8) ? 30 : 55;
        r       = $urandom_range(99);
        if (r >= 88) begin
            // random write, release or unused mode on any slot
            mode = 2'($urandom_range(3, 1));
        end else if (r >= get_pct && held_slots.size() != 0) begin
            slot = SLOT_W'(held_slots[$urandom_range(held_slots.size() - 1)]);
            if (r >= 80 && (dirty_cnt < DIRTY_CAP || dirty[slot])) mode = MODE_WRITE;
            else mode = MODE_RELEASE;
        end
    endtask

    // result side: random back-pressure, plus one long hold-off
    always @(negedge aclk) begin
        if (!long_stall_done && n_sent >= 300) begin
            long_stall_done <= 1'b1;
            stall_left      <= 400;
            m_tready        <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each result transfer with the oldest pending answer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                         $time, m_tdata[2:0], m_tdata[6:3]);
                n_errors++;
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[2:0] != want.status || m_tdata[6:3] != want.slot) begin
                    $display("%0t: mismatch, expected status %0d slot %0d, got status %0d slot %0d",
                             $time, want.status, want.slot, m_tdata[2:0], m_tdata[6:3]);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // reset, directed table, random traffic, drain
    initial begin
        int i;
        int k;
        logic [1:0]        mode;
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [SLOT_W-1:0] slot;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        n_sent          = 0;
        n_errors        = 0;
        cycle_cnt       = 0;
        stall_left      = 0;
        long_stall_done = 1'b0;
        tx_idle_pct     = 10;
        rx_idle_pct     = 59;
        tag_valid       = '0;
        held            = '0;
        dirty           = '0;
        filled          = '0;
        for (i = 0; i < SLOTS; i++) begin
            tag_dev[i] = '0;
            tag_blk[i] = '0;
            rank_of[i] = SLOT_W'(i);
        end
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < N_TOTAL; k++) begin
            // idle phases: sender light / receiver heavy, then swapped, then none
            if (k < N_TOTAL / 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 59;
            end else if (k < 2 * N_TOTAL / 3) begin
                tx_idle_pct = 59;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (k < N_DIRECTED) begin
                send_request(DIRECTED_REQS[k].mode, DIRECTED_REQS[k].dev,
                             DIRECTED_REQS[k].blk, DIRECTED_REQS[k].slot,
                             DIRECTED_REQS[k].typed, DIRECTED_REQS[k].st,
                             DIRECTED_REQS[k].so);
            end else begin
                pick_request(mode, dev, blk, slot);
                send_request(mode, dev, blk, slot, 1'b0, ST_HIT, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (answers_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
